// ----- src/complex_arithmetic_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared property macros for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CAU_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked during reset too.
`define CAU_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation codes and the classification record passed front to back.
// ----------------------------------------------------------------------------
package cau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_e_t;

    typedef struct packed {
        op_e_t op;
        logic  zero_div;
    } class_t;

    localparam int RES_W    = 32;
    localparam int OUT_FRAC = 16;
    localparam int N_STEPS  = RES_W;

endpackage

// ----- src/cau_front.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Accept operand transfers and classify them for the back end.
// ----------------------------------------------------------------------------
module cau_front
    import cau_pkg::*;
#(
    parameter int W = 16
) (
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     mode,
    input  logic [W-1:0]   b_real,
    input  logic [W-1:0]   b_imag,
    input  logic           q_full,
    output logic           q_push,
    output class_t         cls
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Decode the operation and flag a zero divisor up front.
    always_comb begin
        cls.op       = op_e_t'(mode);
        cls.zero_div = (op_e_t'(mode) == OP_DIV) && (b_real == '0) && (b_imag == '0);
    end

endmodule

// ----- src/cau_queue.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit queue
// Two-entry FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cau_queue
    import cau_pkg::*;
#(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output logic [DW-1:0] head_data
);

    logic [DW-1:0] mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_pop;

    // Report full while in reset so nothing is taken in.
    assign full       = (count_reg == 2'd2) || !aresetn;
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/cau_back.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit back end
// Products, sums, scaling, a pipelined restoring divider and saturation.
// ----------------------------------------------------------------------------
module cau_back
    import cau_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_pop,
    input  class_t              cls,
    input  logic signed [W-1:0] a_re,
    input  logic signed [W-1:0] a_im,
    input  logic signed [W-1:0] b_re,
    input  logic signed [W-1:0] b_im,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [RES_W-1:0]    res_re,
    output logic [RES_W-1:0]    res_im,
    output logic                dz,
    output logic                ovf
);

    localparam int PW      = 2 * W;
    localparam int MW      = PW + 1;
    localparam int DW      = PW;
    localparam int SW      = MW + OUT_FRAC;
    localparam int FRAC_IN = W / 2;
    localparam int FRAC_P  = 2 * FRAC_IN;
    localparam int SHL_A   = (FRAC_IN >= OUT_FRAC) ? 0 : OUT_FRAC - FRAC_IN;
    localparam int SHR_A   = (FRAC_IN >= OUT_FRAC) ? FRAC_IN - OUT_FRAC : 0;
    localparam int SHL_M   = (FRAC_P >= OUT_FRAC) ? 0 : OUT_FRAC - FRAC_P;
    localparam int SHR_M   = (FRAC_P >= OUT_FRAC) ? FRAC_P - OUT_FRAC : 0;

    logic en;
    assign en     = !out_valid || out_ready;
    assign in_pop = en;

    // Products and add/sub sums.
    logic                 v1_reg;
    class_t               c1_reg;
    logic signed [MW-1:0] sr1_reg, si1_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, q_r_reg, q_i_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg   <= cls;
            sr1_reg  <= (cls.op == OP_SUB) ? MW'(a_re) - MW'(b_re) : MW'(a_re) + MW'(b_re);
            si1_reg  <= (cls.op == OP_SUB) ? MW'(a_im) - MW'(b_im) : MW'(a_im) + MW'(b_im);
            p_rr_reg <= a_re * b_re;
            p_ii_reg <= a_im * b_im;
            p_ri_reg <= a_re * b_im;
            p_ir_reg <= a_im * b_re;
            q_r_reg  <= b_re * b_re;
            q_i_reg  <= b_im * b_im;
        end
    end

    // Combine per operation and form the divisor.
    logic                 v2_reg;
    class_t               c2_reg;
    logic signed [MW-1:0] vr2_reg, vi2_reg;
    logic [DW-1:0]        d2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c2_reg <= c1_reg;
            d2_reg <= DW'($unsigned(q_r_reg)) + DW'($unsigned(q_i_reg));
            case (c1_reg.op)
                OP_ADD, OP_SUB: begin
                    vr2_reg <= sr1_reg;
                    vi2_reg <= si1_reg;
                end
                OP_MUL: begin
                    vr2_reg <= MW'(p_rr_reg) - MW'(p_ii_reg);
                    vi2_reg <= MW'(p_ri_reg) + MW'(p_ir_reg);
                end
                default: begin
                    vr2_reg <= c1_reg.zero_div ? '0 : MW'(p_rr_reg) + MW'(p_ii_reg);
                    vi2_reg <= c1_reg.zero_div ? '0 : MW'(p_ir_reg) - MW'(p_ri_reg);
                end
            endcase
        end
    end

    // Sign and magnitude.
    logic          v3_reg;
    class_t        c3_reg;
    logic [DW-1:0] d3_reg;
    logic          n3_reg [2];
    logic [MW-1:0] m3_reg [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            c3_reg    <= c2_reg;
            d3_reg    <= d2_reg;
            n3_reg[0] <= vr2_reg[MW-1];
            n3_reg[1] <= vi2_reg[MW-1];
            m3_reg[0] <= vr2_reg[MW-1] ? $unsigned(-vr2_reg) : $unsigned(vr2_reg);
            m3_reg[1] <= vi2_reg[MW-1] ? $unsigned(-vi2_reg) : $unsigned(vi2_reg);
        end
    end

    // Divider pipeline; index 0 is the setup stage.
    logic             sv_reg   [N_STEPS+1];
    logic             sdz_reg  [N_STEPS+1];
    logic             sdiv_reg [N_STEPS+1];
    logic [DW-1:0]    sd_reg   [N_STEPS+1];
    logic             sn_reg   [N_STEPS+1][2];
    logic             so_reg   [N_STEPS+1][2];
    logic [RES_W-1:0] sq_reg   [N_STEPS+1][2];
    logic [DW-1:0]    sr_reg   [N_STEPS+1][2];
    logic [RES_W-1:0] sl_reg   [N_STEPS+1][2];

    logic          is_div3;
    logic [SW-1:0] scl3 [2];
    logic [MW-1:0] nhi3 [2];
    assign is_div3 = (c3_reg.op == OP_DIV) && !c3_reg.zero_div;

    for (genvar l = 0; l < 2; l++) begin : g_setup
        always_comb begin
            nhi3[l] = m3_reg[l] >> OUT_FRAC;
            if (c3_reg.op == OP_MUL) begin
                scl3[l] = (SW'(m3_reg[l]) << SHL_M) >> SHR_M;
            end else begin
                scl3[l] = (SW'(m3_reg[l]) << SHL_A) >> SHR_A;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sn_reg[0][l] <= n3_reg[l];
                if (is_div3) begin
                    // Quotient of 2^32 or more saturates anyway.
                    so_reg[0][l] <= nhi3[l] >= {1'b0, d3_reg};
                    sq_reg[0][l] <= '0;
                    sr_reg[0][l] <= nhi3[l][DW-1:0];
                    sl_reg[0][l] <= {m3_reg[l][OUT_FRAC-1:0], {OUT_FRAC{1'b0}}};
                end else begin
                    so_reg[0][l] <= |scl3[l][SW-1:RES_W];
                    sq_reg[0][l] <= scl3[l][RES_W-1:0];
                    sr_reg[0][l] <= '0;
                    sl_reg[0][l] <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sdz_reg[0]  <= c3_reg.zero_div;
            sdiv_reg[0] <= is_div3;
            sd_reg[0]   <= d3_reg;
        end
    end

    for (genvar k = 1; k <= N_STEPS; k++) begin : g_step
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DW:0] trial;
            logic        ge;
            always_comb begin
                trial = {sr_reg[k-1][l], sl_reg[k-1][l][RES_W-1]};
                ge    = trial >= {1'b0, sd_reg[k-1]};
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    sn_reg[k][l] <= sn_reg[k-1][l];
                    so_reg[k][l] <= so_reg[k-1][l];
                    sl_reg[k][l] <= sl_reg[k-1][l] << 1;
                    if (sdiv_reg[k-1] && !so_reg[k-1][l]) begin
                        sq_reg[k][l] <= {sq_reg[k-1][l][RES_W-2:0], ge};
                        sr_reg[k][l] <= ge ? DW'(trial - {1'b0, sd_reg[k-1]})
                                           : trial[DW-1:0];
                    end else begin
                        sq_reg[k][l] <= sq_reg[k-1][l];
                        sr_reg[k][l] <= sr_reg[k-1][l];
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sdz_reg[k]  <= sdz_reg[k-1];
                sdiv_reg[k] <= sdiv_reg[k-1];
                sd_reg[k]   <= sd_reg[k-1];
            end
        end
    end

    // Saturate into the output register.
    logic             sat [2];
    logic [RES_W-1:0] val [2];
    for (genvar l = 0; l < 2; l++) begin : g_sat
        always_comb begin
            if (sn_reg[N_STEPS][l]) begin
                sat[l] = so_reg[N_STEPS][l] || (sq_reg[N_STEPS][l] > {1'b1, {RES_W-1{1'b0}}});
                val[l] = sat[l] ? {1'b1, {RES_W-1{1'b0}}} : -sq_reg[N_STEPS][l];
            end else begin
                sat[l] = so_reg[N_STEPS][l] || sq_reg[N_STEPS][l][RES_W-1];
                val[l] = sat[l] ? {1'b0, {RES_W-1{1'b1}}} : sq_reg[N_STEPS][l];
            end
        end
    end

    logic             ov_reg;
    logic [RES_W-1:0] rr_reg, ri_reg;
    logic             dz_reg, of_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rr_reg <= val[0];
            ri_reg <= val[1];
            dz_reg <= sdz_reg[N_STEPS];
            of_reg <= sat[0] || sat[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int k = 0; k <= N_STEPS; k++) begin
                sv_reg[k] <= 1'b0;
            end
            ov_reg <= 1'b0;
        end else if (en) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            sv_reg[0] <= v3_reg;
            for (int k = 1; k <= N_STEPS; k++) begin
                sv_reg[k] <= sv_reg[k-1];
            end
            ov_reg <= sv_reg[N_STEPS];
        end
    end

    assign out_valid = ov_reg;
    assign res_re    = rr_reg;
    assign res_im    = ri_reg;
    assign dz        = dz_reg;
    assign ovf       = of_reg;

endmodule

// ----- src/complex_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply or divide two complex fixed-point operands.
// ----------------------------------------------------------------------------
// One operand pair is taken per clock and one result comes out per clock in
// arrival order while the result side does not stall; every item passes
// through the 32 step stages of the quotient pipeline, so results stay in
// order. Operands are signed with OPERAND_WIDTH/2 fraction bits; results are
// signed Q16.16, truncated toward zero and saturated with the overflow flag
// raised. A zero divisor returns zeros with div_by_zero set. A two-entry
// queue sits between the input and the arithmetic pipeline, which holds as
// a whole when the result side stalls.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // a_real, a_imag, b_real, b_imag from the lowest bit up
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic [1:0]                   s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // res_real, res_imag
    output logic [2*RES_W-1:0]           m_axis_tdata,
    // div_by_zero, overflow
    output logic [1:0]                   m_axis_tuser
);

    localparam int W  = OPERAND_WIDTH;
    localparam int QW = $bits(class_t) + 4 * W;

    logic [W-1:0] ar, ai, br, bi;
    assign ar = s_axis_tdata[W-1:0];
    assign ai = s_axis_tdata[2*W-1:W];
    assign br = s_axis_tdata[3*W-1:2*W];
    assign bi = s_axis_tdata[4*W-1:3*W];

    class_t        cls_in, cls_hd;
    logic          q_full, q_push, q_pop, q_hv;
    logic [QW-1:0] q_hd;

    // Classify at the door.
    cau_front #(.W(W)) u_front (
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .mode    (s_axis_tuser),
        .b_real  (br),
        .b_imag  (bi),
        .q_full  (q_full),
        .q_push  (q_push),
        .cls     (cls_in)
    );

    cau_queue #(.DW(QW)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  ({cls_in, bi, br, ai, ar}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_hv),
        .head_data  (q_hd)
    );

    assign cls_hd = q_hd[QW-1:4*W];

    logic [RES_W-1:0] res_re, res_im;
    logic             dz, ovf;

    cau_back #(.W(W)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_hv),
        .in_pop    (q_pop),
        .cls       (cls_hd),
        .a_re      ($signed(q_hd[W-1:0])),
        .a_im      ($signed(q_hd[2*W-1:W])),
        .b_re      ($signed(q_hd[3*W-1:2*W])),
        .b_im      ($signed(q_hd[4*W-1:3*W])),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res_re    (res_re),
        .res_im    (res_im),
        .dz        (dz),
        .ovf       (ovf)
    );

    assign m_axis_tdata = {res_im, res_re};
    assign m_axis_tuser = {ovf, dz};

    // Result checks for the assertions below.
    logic res_zero, res_at_lim;
    assign res_zero   = (res_re == '0) && (res_im == '0);
    assign res_at_lim = (res_re == 32'h7FFFFFFF) || (res_re == 32'h80000000) ||
                        (res_im == 32'h7FFFFFFF) || (res_im == 32'h80000000);

    // A zero divisor always reports a clean zero result.
    `CAU_ASSERT_IMPLY(a_dz_zero, aclk, aresetn, m_axis_tvalid && dz, res_zero && !ovf)
    // Overflow means at least one part sits on a saturation limit.
    `CAU_ASSERT_IMPLY(a_ovf_lim, aclk, aresetn, m_axis_tvalid && ovf, res_at_lim)
    // Nothing comes out right after reset.
    `CAU_ASSERT_NEXT(a_rst_idle, aclk, !aresetn, !m_axis_tvalid)

endmodule
